// File: sv/clrle_pkg.sv
package clrle_pkg;

	localparam int LEN_W   = 4;
	localparam int SYM_W   = 5;
	localparam int EXT_W   = 7;
	localparam int CNT_W   = 8;
	localparam int SLOTS   = 4;
	localparam int SLOT_W  = $clog2(SLOTS);

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [EXT_W-1:0]  ext_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SLOT_W-1:0] slot_t;

	localparam sym_t SYM_REP_PREV  = sym_t'(16);
	localparam sym_t SYM_ZERO_SHRT = sym_t'(17);
	localparam sym_t SYM_ZERO_LONG = sym_t'(18);

	localparam cnt_t REP_MIN       = cnt_t'(3);
	localparam cnt_t REP_MAX       = cnt_t'(6);
	localparam cnt_t ZERO_SHRT_MIN = cnt_t'(3);
	localparam cnt_t ZERO_LONG_MIN = cnt_t'(11);
	localparam cnt_t ZERO_LONG_MAX = cnt_t'(138);

	typedef struct packed {
		sym_t symbol;
		ext_t extra;
	} code_t;

	typedef struct packed {
		slot_t n;
		code_t c0;
		code_t c1;
	} flush_t;

	// Codes that close an open run of the given value with p copies outstanding.
	function automatic flush_t run_flush(logic active, len_t value, cnt_t p);
		flush_t res;
		res = '0;
		if (active) begin
			if (value == '0) begin
				if (p >= ZERO_LONG_MIN) begin
					res.n = slot_t'(1);
					res.c0.symbol = SYM_ZERO_LONG;
					res.c0.extra = ext_t'(p - ZERO_LONG_MIN);
				end else if (p >= ZERO_SHRT_MIN) begin
					res.n = slot_t'(1);
					res.c0.symbol = SYM_ZERO_SHRT;
					res.c0.extra = ext_t'(p - ZERO_SHRT_MIN);
				end else begin
					res.n = slot_t'(p[1:0]);
				end
			end else begin
				if (p >= REP_MIN) begin
					res.n = slot_t'(1);
					res.c0.symbol = SYM_REP_PREV;
					res.c0.extra = ext_t'(p - REP_MIN);
				end else begin
					res.n = slot_t'(p[1:0]);
					res.c0.symbol = sym_t'(value);
					res.c1.symbol = sym_t'(value);
				end
			end
		end
		return res;
	endfunction

endpackage

// File: sv/code_length_run_length_encoder.sv
// Channel  Dir  tdata                                      tuser  tlast
// s_*      in   [3:0] code_length, pad to 8                 -      last_symbol
// m_*      out  [4:0] symbol, [11:5] extra, pad to 16       -      last_of_item
// An input transfer is taken in a single handshake; its codes (up to three)
// are computed at once and held in a small result buffer that drains one code
// per cycle while m_tready is high.
// The next item is accepted in the same cycle as the last code of the previous
// one leaves. Reset clears the run state and empties the result buffer.
module code_length_run_length_encoder
	import clrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [3:0] code_length, [7:4] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [4:0] symbol, [11:5] extra_value, [15:12] zero
	output logic        m_tlast
);

	len_t  run_value_q;
	cnt_t  pending_q;
	logic  run_active_q;
	code_t ent_q [SLOTS];
	slot_t cnt_q;
	slot_t idx_q;

	len_t   len;
	logic   hit;
	logic   rep;
	cnt_t   np_inc;
	cnt_t   np;
	flush_t fa;
	flush_t fb;
	code_t  ent_d [SLOTS];
	slot_t  n_d;
	code_t  lit;
	code_t  rep_code;
	code_t  cur;
	logic   take;
	logic   drain_done;
	logic   accept;

	always_comb begin
		len = s_tdata[LEN_W-1:0];
		hit = run_active_q && (len == run_value_q);
		np_inc = pending_q + cnt_t'(1);
		if (len == '0) begin
			rep = np_inc >= ZERO_LONG_MAX;
			rep_code.symbol = SYM_ZERO_LONG;
			rep_code.extra = ext_t'(ZERO_LONG_MAX - ZERO_LONG_MIN);
		end else begin
			rep = np_inc >= REP_MAX;
			rep_code.symbol = SYM_REP_PREV;
			rep_code.extra = ext_t'(REP_MAX - REP_MIN);
		end
		if (hit) begin
			np = rep ? '0 : np_inc;
		end else begin
			np = (len == '0) ? cnt_t'(1) : '0;
		end
		lit.symbol = sym_t'(len);
		lit.extra = '0;
		fa = run_flush(run_active_q, run_value_q, pending_q);
		fb = run_flush(1'b1, len, np);

		for (int k = 0; k < SLOTS; k++) begin
			ent_d[k] = '0;
		end
		n_d = '0;
		if (hit) begin
			if (rep) begin
				ent_d[n_d] = rep_code;
				n_d = n_d + slot_t'(1);
			end
		end else begin
			if (fa.n > slot_t'(0)) begin
				ent_d[n_d] = fa.c0;
				n_d = n_d + slot_t'(1);
			end
			if (fa.n > slot_t'(1)) begin
				ent_d[n_d] = fa.c1;
				n_d = n_d + slot_t'(1);
			end
			if (len != '0) begin
				ent_d[n_d] = lit;
				n_d = n_d + slot_t'(1);
			end
		end
		if (s_tlast) begin
			if (fb.n > slot_t'(0)) begin
				ent_d[n_d] = fb.c0;
				n_d = n_d + slot_t'(1);
			end
			if (fb.n > slot_t'(1)) begin
				ent_d[n_d] = fb.c1;
				n_d = n_d + slot_t'(1);
			end
		end
	end

	assign cur        = ent_q[idx_q];
	assign m_tvalid   = cnt_q != '0;
	assign m_tlast    = idx_q == (cnt_q - slot_t'(1));
	assign m_tdata    = {4'b0000, cur.extra, cur.symbol};
	assign take       = m_tvalid && m_tready;
	assign drain_done = take && m_tlast;
	assign s_tready   = (cnt_q == '0) || drain_done;
	assign accept     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= '0;
			pending_q    <= '0;
			run_active_q <= 1'b0;
			cnt_q        <= '0;
			idx_q        <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				run_value_q  <= '0;
				pending_q    <= '0;
				run_active_q <= 1'b0;
			end else begin
				run_value_q  <= len;
				pending_q    <= np;
				run_active_q <= 1'b1;
			end
			cnt_q <= n_d;
			idx_q <= '0;
		end else if (drain_done) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + slot_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < SLOTS; k++) begin
				ent_q[k] <= ent_d[k];
			end
		end
	end

endmodule

// File: dv/tb_code_length_run_length_encoder.sv
`timescale 1ns / 100ps

module tb_code_length_run_length_encoder;
	import clrle_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		sym_t symbol;
		ext_t extra;
		logic last;
	} code_exp_t;

	typedef struct packed {
		len_t len;
		logic last;
		logic hold;
	} len_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // [3:0] code_length, [7:4] zero
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // [4:0] symbol, [11:5] extra_value, [15:12] zero
	logic        m_tlast;

	len_item_t   pending_lengths[$];
	len_item_t   next_len;
	code_exp_t   expected_codes[$];
	code_exp_t   item_codes[$];
	code_exp_t   want;

	len_t        run_len = '0;
	cnt_t        run_pend = '0;
	logic        run_open = 1'b0;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int          cycles = 0;

	code_length_run_length_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic add_code(input sym_t s, input ext_t e);
		item_codes.insert(item_codes.size(), code_exp_t'{symbol: s, extra: e, last: 1'b0});
	endtask

	task automatic close_run();
		if (run_open) begin
			if (run_len == '0) begin
				if (run_pend >= ZERO_LONG_MIN) begin
					add_code(SYM_ZERO_LONG, ext_t'(run_pend - ZERO_LONG_MIN));
				end else if (run_pend >= ZERO_SHRT_MIN) begin
					add_code(SYM_ZERO_SHRT, ext_t'(run_pend - ZERO_SHRT_MIN));
				end else begin
					for (int k = 0; k < run_pend; k++)
						add_code(sym_t'(0), ext_t'(0));
				end
			end else begin
				if (run_pend >= REP_MIN) begin
					add_code(SYM_REP_PREV, ext_t'(run_pend - REP_MIN));
				end else begin
					for (int k = 0; k < run_pend; k++)
						add_code(sym_t'(run_len), ext_t'(0));
				end
			end
		end
		run_pend = '0;
		run_open = 1'b0;
	endtask

	task automatic encode_length(input len_t len, input logic last);
		item_codes.delete();
		if (run_open && len == run_len) begin
			run_pend = run_pend + cnt_t'(1);
			if (len == '0) begin
				if (run_pend >= ZERO_LONG_MAX) begin
					add_code(SYM_ZERO_LONG, ext_t'(ZERO_LONG_MAX - ZERO_LONG_MIN));
					run_pend = '0;
				end
			end else if (run_pend >= REP_MAX) begin
				add_code(SYM_REP_PREV, ext_t'(REP_MAX - REP_MIN));
				run_pend = '0;
			end
		end else begin
			close_run();
			run_len = len;
			run_open = 1'b1;
			if (len == '0) begin
				run_pend = cnt_t'(1);
			end else begin
				add_code(sym_t'(len), ext_t'(0));
				run_pend = '0;
			end
		end
		if (last) begin
			close_run();
			run_len = '0;
		end
		if (item_codes.size() > 0)
			item_codes[item_codes.size() - 1].last = 1'b1;
		foreach (item_codes[i])
			expected_codes.insert(expected_codes.size(), item_codes[i]);
	endtask

	task automatic add_run(input len_t len, input int count, input logic last);
		for (int i = 0; i < count; i++)
			pending_lengths.insert(pending_lengths.size(),
				len_item_t'{len: len, last: last && (i == count - 1), hold: 1'b0});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				encode_length(len_t'(s_tdata[LEN_W-1:0]), s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_lengths.size() > 0 && $urandom_range(99) >= send_idle_pct &&
						(!pending_lengths[0].hold || expected_codes.size() == 0)) begin
					next_len = pending_lengths.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, next_len.len};
					s_tlast <= next_len.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected transfer: symbol %0d, extra_value %0d",
						m_tdata[SYM_W-1:0], m_tdata[SYM_W+EXT_W-1:SYM_W]);
					errors++;
				end else begin
					want = expected_codes.pop_front();
					if (m_tdata[SYM_W-1:0] !== want.symbol) begin
						$error("symbol: expected %0d, actual %0d", want.symbol,
							m_tdata[SYM_W-1:0]);
						errors++;
					end
					if (m_tdata[SYM_W+EXT_W-1:SYM_W] !== want.extra) begin
						$error("extra_value: expected %0d, actual %0d", want.extra,
							m_tdata[SYM_W+EXT_W-1:SYM_W]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_item: expected %0d, actual %0d", want.last, m_tlast);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int   count;
		int   run;
		logic held;
		logic lst;
		len_t v;

		add_run(len_t'(15), 1, 1'b1);
		add_run(len_t'(0), 1, 1'b1);
		add_run(len_t'(3), 3, 1'b0);
		add_run(len_t'(4), 4, 1'b1);
		add_run(len_t'(9), 7, 1'b0);
		add_run(len_t'(9), 1, 1'b1);
		add_run(len_t'(0), 2, 1'b0);
		add_run(len_t'(1), 1, 1'b0);
		add_run(len_t'(0), 3, 1'b0);
		add_run(len_t'(2), 1, 1'b1);
		pending_lengths[pending_lengths.size() - 1].hold = 1'b1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			if (phase == 0)
				add_run(len_t'(0), $urandom_range(145, 138), 1'b1);
			count = 0;
			held = 1'b0;
			while (count < 30) begin
				if ($urandom_range(99) < 40)
					v = '0;
				else
					v = len_t'($urandom_range(15, 1));
				if (v == '0 && $urandom_range(9) == 0)
					run = $urandom_range(150, 100);
				else if (v == '0)
					run = $urandom_range(14, 1);
				else
					run = $urandom_range(9, 1);
				lst = ($urandom_range(4) == 0);
				add_run(v, run, lst);
				count += run;
				if (!held && count >= 15) begin
					pending_lengths[pending_lengths.size() - 1].hold = 1'b1;
					held = 1'b1;
				end
			end
			while (pending_lengths.size() != 0 || s_tvalid || expected_codes.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_codes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
